// File: hw/rtl/oph_pkg.sv
`default_nettype none

package oph_pkg;

  localparam int DEF_MAX_ELEMENTS = 64;
  localparam int DEF_COUNT_WIDTH  = 24;

  localparam int ACTION_W    = 2;
  localparam int ELEMENT_W   = 6;
  localparam int ROW_W       = 6;
  localparam int COLUMN_W    = 7;
  localparam int LEN_W       = 7;
  localparam int COUNT_OUT_W = 30;

  localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

  typedef logic [ACTION_W-1:0] action_t;

  localparam action_t ACT_CLEAR = 2'd0;
  localparam action_t ACT_ADD   = 2'd1;
  localparam action_t ACT_READ  = 2'd2;
  localparam action_t ACT_FIRST = 2'd3;

  typedef struct packed {
    logic capture;
    logic sweep_start;
    logic sweep_step;
    logic first_rd;
    logic first_wr;
    logic pair_rd;
    logic pair_wr;
    logic read_rd;
    logic commit;
    logic load_result;
  } oph_cmd_t;

  typedef struct packed {
    action_t action;
    logic    range_err;
    logic    pos_zero;
    logic    walk_last;
    logic    sweep_last;
    logic    out_free;
  } oph_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/oph_ctrl.sv
`default_nettype none

module oph_ctrl
  import oph_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     request_valid,
  output logic          request_stall,
  input  wire oph_sts_t sts,
  output oph_cmd_t      cmd
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DECODE   = 4'd2;
  localparam logic [3:0] S_FIRST_WR = 4'd3;
  localparam logic [3:0] S_PAIR_RD  = 4'd4;
  localparam logic [3:0] S_PAIR_WR  = 4'd5;
  localparam logic [3:0] S_COMMIT   = 4'd6;
  localparam logic [3:0] S_DONE     = 4'd7;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       clear_reply;
  logic       clear_reply_next;

  assign request_stall = (state != S_IDLE);

  always_comb begin
    state_next       = state;
    clear_reply_next = clear_reply;
    cmd              = '0;
    case (state)
      S_CLEAR: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_next = clear_reply ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (request_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.action)
          ACT_CLEAR: begin
            cmd.sweep_start  = 1'b1;
            clear_reply_next = 1'b1;
            state_next       = S_CLEAR;
          end
          ACT_ADD: begin
            if (sts.range_err) begin
              state_next = S_DONE;
            end else if (sts.pos_zero) begin
              cmd.first_rd = 1'b1;
              state_next   = S_FIRST_WR;
            end else begin
              state_next = S_PAIR_RD;
            end
          end
          default: begin
            if (!sts.range_err) begin
              cmd.read_rd = 1'b1;
            end
            state_next = S_DONE;
          end
        endcase
      end
      S_FIRST_WR: begin
        cmd.first_wr = 1'b1;
        state_next   = S_COMMIT;
      end
      S_PAIR_RD: begin
        cmd.pair_rd = 1'b1;
        state_next  = S_PAIR_WR;
      end
      S_PAIR_WR: begin
        cmd.pair_wr = 1'b1;
        state_next  = sts.walk_last ? S_COMMIT : S_PAIR_RD;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_result  = 1'b1;
          clear_reply_next = 1'b0;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clear_reply <= 1'b0;
    end else begin
      state       <= state_next;
      clear_reply <= clear_reply_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |-> sts.out_free)
    else $error("result loaded while output register busy");

  a_walk_next: assert property (@(posedge clk) disable iff (rst)
    cmd.pair_wr |=> (state == S_PAIR_RD) || (state == S_COMMIT))
    else $error("pair walk left its loop");

  a_sweep_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) && sts.sweep_last |=> (state == S_IDLE) || (state == S_DONE))
    else $error("clear sweep did not end");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/oph_datapath.sv
`default_nettype none

module oph_datapath
  import oph_pkg::*;
#(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
  parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire oph_cmd_t               cmd,
  output oph_sts_t                    sts,
  input  wire action_t                action,
  input  wire logic [ELEMENT_W-1:0]   element,
  input  wire logic [ROW_W-1:0]       row,
  input  wire logic [COLUMN_W-1:0]    column,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [LEN_W-1:0]       sequence_length,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output logic [COUNT_OUT_W-1:0]      count,
  output logic                        status
);

  localparam int IDX_W      = $clog2(MAX_ELEMENTS);
  localparam int LW         = $clog2(MAX_ELEMENTS + 1);
  localparam int CW         = (LW > COLUMN_W) ? LW : COLUMN_W;
  localparam int PAIR_DEPTH = MAX_ELEMENTS * MAX_ELEMENTS;
  localparam int PA_W       = $clog2(PAIR_DEPTH);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX    = '1;
  localparam logic [COUNT_OUT_W-1:0] MARGIN_MAX = '1;

  function automatic logic [COUNT_OUT_W-1:0] clip(input logic [COUNT_WIDTH-1:0] v);
    logic [31:0] w;
    w    = 32'(v);
    clip = (w > 32'(MARGIN_MAX)) ? MARGIN_MAX : w[COUNT_OUT_W-1:0];
  endfunction

  // captured request
  action_t              action_q;
  logic [ELEMENT_W-1:0] element_q;
  logic [ROW_W-1:0]     row_q;
  logic [COLUMN_W-1:0]  column_q;

  logic [LEN_W-1:0] seq_len;
  logic [LW-1:0]    pos;
  logic [LW-1:0]    k;
  logic [PA_W-1:0]  sweep;
  logic [IDX_W-1:0] a_q;

  logic [CW-1:0]    len_c;
  logic [LW-1:0]    len;
  logic [LW-1:0]    pos_eff;
  logic [LW-1:0]    pos_inc;
  logic [LW-1:0]    pos_next;
  logic [IDX_W-1:0] elem_idx;
  logic [IDX_W-1:0] row_idx;
  logic [IDX_W-1:0] col_idx;
  logic             range_err;
  logic             margin_sel;
  logic             clr_small;

  logic [COUNT_WIDTH-1:0] pair_mem [PAIR_DEPTH];
  logic [COUNT_WIDTH-1:0] pair_q;
  logic [COUNT_WIDTH-1:0] pair_wdata;
  logic [PA_W-1:0]        pair_waddr;
  logic [PA_W-1:0]        pair_raddr;
  logic                   pair_we;

  logic [COUNT_OUT_W-1:0] margin_mem [MAX_ELEMENTS];
  logic [COUNT_OUT_W-1:0] margin_q;
  logic [COUNT_OUT_W-1:0] margin_wdata;
  logic [IDX_W-1:0]       margin_waddr;
  logic [IDX_W-1:0]       margin_raddr;
  logic                   margin_we;

  logic [COUNT_WIDTH-1:0] first_mem [MAX_ELEMENTS];
  logic [COUNT_WIDTH-1:0] first_q;
  logic [COUNT_WIDTH-1:0] first_wdata;
  logic [IDX_W-1:0]       first_waddr;
  logic [IDX_W-1:0]       first_raddr;
  logic                   first_we;

  logic [IDX_W-1:0] earlier_mem [MAX_ELEMENTS];
  logic [IDX_W-1:0] earlier_q;

  logic [COUNT_OUT_W-1:0] res_count;

  assign cfg_ready = 1'b1;

  // effective length, clamped to 1..MAX_ELEMENTS
  always_comb begin
    if (seq_len == '0) begin
      len_c = CW'(1);
    end else if (CW'(seq_len) > CW'(MAX_ELEMENTS)) begin
      len_c = CW'(MAX_ELEMENTS);
    end else begin
      len_c = CW'(seq_len);
    end
  end

  assign len      = LW'(len_c);
  assign pos_eff  = (pos >= len) ? '0 : pos;
  assign pos_inc  = pos_eff + LW'(1);
  assign pos_next = (pos_inc >= len) ? '0 : pos_inc;
  assign elem_idx = IDX_W'(element_q);
  assign row_idx  = IDX_W'(row_q);
  assign col_idx  = IDX_W'(column_q);

  assign margin_sel = (CW'(column_q) == len_c);

  always_comb begin
    case (action_q)
      ACT_ADD:   range_err = (CW'(element_q) >= len_c);
      ACT_READ:  range_err = (CW'(row_q) >= len_c) || (CW'(column_q) > len_c);
      ACT_FIRST: range_err = (CW'(row_q) >= len_c);
      default:   range_err = 1'b0;
    endcase
  end

  assign clr_small = cmd.sweep_step && (sweep < PA_W'(MAX_ELEMENTS));

  // pair counts
  always_comb begin
    pair_we    = 1'b0;
    pair_waddr = sweep;
    pair_wdata = '0;
    if (cmd.sweep_step) begin
      pair_we = 1'b1;
    end else if (cmd.pair_wr) begin
      pair_we    = 1'b1;
      pair_waddr = PA_W'(int'(a_q) * MAX_ELEMENTS + int'(elem_idx));
      pair_wdata = (pair_q == CNT_MAX) ? pair_q : pair_q + COUNT_WIDTH'(1);
    end
  end

  assign pair_raddr = cmd.pair_rd ? PA_W'(int'(earlier_q) * MAX_ELEMENTS + int'(elem_idx))
                                  : PA_W'(int'(row_idx) * MAX_ELEMENTS + int'(col_idx));

  always_ff @(posedge clk) begin
    if (pair_we) begin
      pair_mem[pair_waddr] <= pair_wdata;
    end
    if (cmd.pair_rd || cmd.read_rd) begin
      pair_q <= pair_mem[pair_raddr];
    end
  end

  // row margins
  always_comb begin
    margin_we    = 1'b0;
    margin_waddr = IDX_W'(sweep);
    margin_wdata = '0;
    if (clr_small) begin
      margin_we = 1'b1;
    end else if (cmd.pair_wr) begin
      margin_we    = 1'b1;
      margin_waddr = a_q;
      margin_wdata = (margin_q == MARGIN_MAX) ? margin_q : margin_q + COUNT_OUT_W'(1);
    end
  end

  assign margin_raddr = cmd.pair_rd ? earlier_q : row_idx;

  always_ff @(posedge clk) begin
    if (margin_we) begin
      margin_mem[margin_waddr] <= margin_wdata;
    end
    if (cmd.pair_rd || cmd.read_rd) begin
      margin_q <= margin_mem[margin_raddr];
    end
  end

  // first-position counts
  always_comb begin
    first_we    = 1'b0;
    first_waddr = IDX_W'(sweep);
    first_wdata = '0;
    if (clr_small) begin
      first_we = 1'b1;
    end else if (cmd.first_wr) begin
      first_we    = 1'b1;
      first_waddr = elem_idx;
      first_wdata = (first_q == CNT_MAX) ? first_q : first_q + COUNT_WIDTH'(1);
    end
  end

  assign first_raddr = cmd.first_rd ? elem_idx : row_idx;

  always_ff @(posedge clk) begin
    if (first_we) begin
      first_mem[first_waddr] <= first_wdata;
    end
    if (cmd.first_rd || cmd.read_rd) begin
      first_q <= first_mem[first_raddr];
    end
  end

  // elements of the current sequence
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      earlier_mem[IDX_W'(pos_eff)] <= elem_idx;
    end
    earlier_q <= earlier_mem[IDX_W'(k)];
  end

  always_comb begin
    res_count = '0;
    if (!range_err) begin
      case (action_q)
        ACT_READ:  res_count = margin_sel ? margin_q : clip(pair_q);
        ACT_FIRST: res_count = clip(first_q);
        default:   res_count = '0;
      endcase
    end
  end

  always_comb begin
    sts.action     = action_q;
    sts.range_err  = range_err;
    sts.pos_zero   = (pos_eff == '0);
    sts.walk_last  = (k == pos_eff);
    sts.sweep_last = (sweep == PA_W'(PAIR_DEPTH - 1));
    sts.out_free   = !result_valid || !result_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_len      <= LEN_RESET;
      pos          <= '0;
      sweep        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.sweep_start) begin
        sweep <= '0;
        pos   <= '0;
      end else if (cmd.sweep_step) begin
        sweep <= sweep + PA_W'(1);
      end
      if (cmd.commit) begin
        pos <= pos_next;
      end
      if (cfg_valid) begin
        seq_len <= sequence_length;
        pos     <= '0;
      end
      if (cmd.load_result) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_q  <= action;
      element_q <= element;
      row_q     <= row;
      column_q  <= column;
      k         <= '0;
    end
    if (cmd.pair_rd) begin
      a_q <= earlier_q;
      k   <= k + LW'(1);
    end
    if (cmd.load_result) begin
      count  <= res_count;
      status <= range_err;
    end
  end

`ifndef NO_ASSERTIONS
  a_pos_below_len: assert property (@(posedge clk) disable iff (rst)
    pos < len)
    else $error("sequence position past length");

  a_first_at_start: assert property (@(posedge clk) disable iff (rst)
    cmd.first_wr |-> (pos_eff == '0))
    else $error("first count bumped mid-sequence");

  a_walk_bounds: assert property (@(posedge clk) disable iff (rst)
    cmd.pair_wr |-> (k != '0) && (k <= pos_eff))
    else $error("pair walk index out of bounds");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/order_precedence_histogram.sv
// Precedence histogram over a stream of element sequences. Each request
// carries one action: clear all counts, add an element at the next position of
// the current sequence, read a pair count (column equal to the sequence length
// reads the row margin), or read a first-position count; each gives exactly one
// result. An add reads and rewrites the pair and margin counts for every
// earlier element of the sequence, or the first-position count when it opens
// a sequence; a clear sweeps the pair, margin and first-position memories,
// one memory entry per cycle. The same clearing pass runs after reset with
// requests stalled. A new request is taken while a finished result still
// waits. sequence_length writes are always accepted and restart the sequence.
`default_nettype none

module order_precedence_histogram
  import oph_pkg::*;
#(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
  parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   request_valid,
  output logic                        request_stall,
  input  wire action_t                action,
  input  wire logic [ELEMENT_W-1:0]   element,
  input  wire logic [ROW_W-1:0]       row,
  input  wire logic [COLUMN_W-1:0]    column,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [LEN_W-1:0]       sequence_length,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output logic [COUNT_OUT_W-1:0]      count,
  output logic                        status
);

  oph_cmd_t cmd;
  oph_sts_t sts;

  oph_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .sts           (sts),
    .cmd           (cmd)
  );

  oph_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .action          (action),
    .element         (element),
    .row             (row),
    .column          (column),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .sequence_length (sequence_length),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .count           (count),
    .status          (status)
  );

endmodule

`default_nettype wire
